@@ rtl/canny_nms_hysteresis_macros.svh @@
// Assertion macros for the edge thinning block.
`ifndef CANNY_NMS_HYSTERESIS_MACROS_SVH
`define CANNY_NMS_HYSTERESIS_MACROS_SVH
`ifndef SYNTH
`define CNH_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define CNH_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define CNH_ASSERT_IMPL(label, clk, rst, a, c)
`define CNH_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/cnh_pkg.sv @@
// Shared types and constants of the edge thinning block.
`timescale 1ns / 1ps
package cnh_pkg;
   localparam int DEF_MAX_WIDTH  = 640;
   localparam int DEF_MAX_HEIGHT = 480;

   localparam logic [1:0] REG_HIGH   = 2'd0;
   localparam logic [1:0] REG_LOW    = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;

   localparam logic [1:0] DIR_HORZ = 2'd0;
   localparam logic [1:0] DIR_DIAG = 2'd1;
   localparam logic [1:0] DIR_VERT = 2'd2;
   localparam logic [1:0] DIR_ANTI = 2'd3;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_NMS   = 3'd2,
      OP_HYST  = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] tap;     // neighbour slot fetched in this step
      logic       start;   // first step of a pixel
      logic       finish;  // write-back step of a pixel
   } cmd_type;

   typedef struct packed {
      logic rd_valid;
   } status_type;

   function automatic logic [1:0] bin_angle(input logic [11:0] ang);
      logic [11:0] a;
      a = (ang > 12'd1800) ? ang - 12'd1800 : ang;
      if (a <= 12'd225 || a >= 12'd1575) return DIR_HORZ;
      else if (a <= 12'd675) return DIR_DIAG;
      else if (a <= 12'd1125) return DIR_VERT;
      else return DIR_ANTI;
   endfunction
endpackage

@@ rtl/canny_nms_hysteresis.sv @@
// Top level of the Canny suppression and hysteresis back end.
// A load item (mode 0) writes magnitude and binned direction into the frame
// store. The load that completes the frame starts two in-place sweeps over the
// store, suppression then hysteresis, each stepping through the 3x3 window of
// every pixel on the single read port; no item is accepted during the sweeps.
// A read item (mode 1) yields one result after processing; reads before
// processing yield none.
`timescale 1ns / 1ps
module canny_nms_hysteresis #(
   parameter int MAX_WIDTH  = cnh_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cnh_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // magnitude[7:0], angle_tenths[19:8], zero fill
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // edge_value[7:0]
   output logic        rsp_tlast,   // last_pixel
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import cnh_pkg::*;
   `include "canny_nms_hysteresis_macros.svh"

   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic [7:0] high_ff, low_ff;
   logic [9:0] width_ff;
   logic [8:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff <= 8'd100; low_ff <= 8'd80; width_ff <= 10'd640; height_ff <= 9'd480;
      end else if (csr_we) begin
         case (csr_index)
            REG_HIGH:   high_ff <= csr_wdata[7:0];
            REG_LOW:    low_ff <= csr_wdata[7:0];
            REG_WIDTH:  width_ff <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   logic [XW-1:0] eff_w;
   logic [YW-1:0] eff_h;
   always_comb begin
      if (width_ff == '0) eff_w = XW'(1);
      else if (32'(width_ff) > MAX_WIDTH) eff_w = XW'(MAX_WIDTH);
      else eff_w = XW'(width_ff);
      if (height_ff == '0) eff_h = YW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) eff_h = YW'(MAX_HEIGHT);
      else eff_h = YW'(height_ff);
   end

   cmd_type cmd;
   status_type status;
   logic [AW-1:0] addr;
   logic [XW-1:0] pos_x;
   logic [YW-1:0] pos_y;
   logic rd_last, rd_zero;
   logic [7:0] rd_data;
   logic rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic rsp_last_ff;
   logic zero_pend_ff;

   cnh_controller #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_mode(req_tuser),
      .in_ready(req_tready), .out_free(!rsp_valid_ff), .eff_w, .eff_h,
      .cmd, .addr, .pos_x, .pos_y, .rd_last, .rd_zero);

   cnh_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock, .cmd, .status, .addr, .pos_x, .pos_y, .eff_w, .eff_h,
      .high_th(high_ff), .low_th(low_ff), .ld_mag(req_tdata[7:0]),
      .ld_ang(req_tdata[19:8]), .rd_data);

   // An out-of-size read is flagged by the controller with no store access.
   logic zero_now;
   assign zero_now = req_tvalid && req_tready && req_tuser && cmd.op == OP_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0; zero_pend_ff <= 1'b0;
      end else begin
         zero_pend_ff <= zero_now;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         else if (status.rd_valid || (zero_pend_ff && rd_zero)) rsp_valid_ff <= 1'b1;
      end
      if (status.rd_valid) begin
         rsp_data_ff <= rd_data; rsp_last_ff <= rd_last;
      end else if (zero_pend_ff) begin
         rsp_data_ff <= 8'd0; rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   `CNH_ASSERT_NEXT(a_load_no_rsp, clock, reset, cmd.op == OP_LOAD, !status.rd_valid)
   `CNH_ASSERT_IMPL(a_busy_no_accept, clock, reset,
      cmd.op == OP_NMS || cmd.op == OP_HYST, !req_tready)
   `CNH_ASSERT_IMPL(a_no_overrun, clock, reset, status.rd_valid, !rsp_valid_ff)
endmodule

@@ rtl/cnh_datapath.sv @@
// Frame stores, neighbour fetch, suppression and hysteresis datapath.
`timescale 1ns / 1ps
module cnh_datapath #(
   parameter int MAX_WIDTH  = cnh_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cnh_pkg::DEF_MAX_HEIGHT,
   parameter int XW = $clog2(MAX_WIDTH + 1),
   parameter int YW = $clog2(MAX_HEIGHT + 1),
   parameter int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic              clock,
   input  cnh_pkg::cmd_type  cmd,
   output cnh_pkg::status_type status,
   input  logic [AW-1:0]     addr,     // store address of the centre pixel
   input  logic [XW-1:0]     pos_x,
   input  logic [YW-1:0]     pos_y,
   input  logic [XW-1:0]     eff_w,
   input  logic [YW-1:0]     eff_h,
   input  logic [7:0]        high_th,
   input  logic [7:0]        low_th,
   input  logic [7:0]        ld_mag,
   input  logic [11:0]       ld_ang,
   output logic [7:0]        rd_data
);
   import cnh_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

   logic [7:0] mag_mem [DEPTH];
   logic [1:0] dir_mem [DEPTH];

   // Tap coding: 0..8 is the 3x3 window (dy+1)*3+(dx+1); the centre direction is read on every step.
   logic signed [2:0] dy, dx;
   logic signed [XW+1:0] nx;
   logic signed [YW+1:0] ny;
   logic inside_frame;
   logic [AW+XW+1:0] naddr_wide;
   logic [AW-1:0] naddr;

   always_comb begin
      case (cmd.tap)
         4'd0:    begin dy = -3'sd1; dx = -3'sd1; end
         4'd1:    begin dy = -3'sd1; dx =  3'sd0; end
         4'd2:    begin dy = -3'sd1; dx =  3'sd1; end
         4'd3:    begin dy =  3'sd0; dx = -3'sd1; end
         4'd4:    begin dy =  3'sd0; dx =  3'sd0; end
         4'd5:    begin dy =  3'sd0; dx =  3'sd1; end
         4'd6:    begin dy =  3'sd1; dx = -3'sd1; end
         4'd7:    begin dy =  3'sd1; dx =  3'sd0; end
         4'd8:    begin dy =  3'sd1; dx =  3'sd1; end
         default: begin dy =  3'sd0; dx =  3'sd0; end
      endcase
      nx = $signed({2'b0, pos_x}) + (XW + 2)'(dx);
      ny = $signed({2'b0, pos_y}) + (YW + 2)'(dy);
      inside_frame = (nx >= 0) && (ny >= 0) && (nx < $signed({2'b0, eff_w}))
                     && (ny < $signed({2'b0, eff_h}));
      naddr_wide = (AW + XW + 2)'($signed({{(XW+2){1'b0}}, addr})
                   + (AW + XW + 2)'(dy) * (AW + XW + 2)'($signed({2'b0, eff_w}))
                   + (AW + XW + 2)'(dx));
      naddr = naddr_wide[AW-1:0];
   end

   logic [7:0] rd_ff;
   logic [1:0] dir_rd_ff;
   logic       tap_in_ff, tap_in_in;
   logic [3:0] tap_ff;
   logic [7:0] wr_data;
   logic       wr_en;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         mag_mem[addr] <= ld_mag;
         dir_mem[addr] <= bin_angle(ld_ang);
      end else if (wr_en) begin
         mag_mem[addr] <= wr_data;
      end
      rd_ff     <= mag_mem[(cmd.op == OP_READ) ? addr : naddr];
      dir_rd_ff <= dir_mem[addr];
   end

   assign tap_in_in = inside_frame;
   always_ff @(posedge clock) begin
      tap_in_ff <= tap_in_in;
      tap_ff    <= cmd.tap;
   end

   // Window gathered from the registered read of each fetch.
   // The direction of the centre is read from the first step of each pixel on.
   logic [7:0] centre_ff, n1_ff, n2_ff;
   logic       strong_ff;
   logic [7:0] tv;
   logic [3:0] t1, t2;

   assign tv = tap_in_ff ? rd_ff : 8'd0;

   always_comb begin
      case (dir_rd_ff)
         DIR_HORZ: begin t1 = 4'd3; t2 = 4'd5; end
         DIR_DIAG: begin t1 = 4'd8; t2 = 4'd0; end
         DIR_VERT: begin t1 = 4'd7; t2 = 4'd1; end
         default:  begin t1 = 4'd2; t2 = 4'd6; end
      endcase
   end

   logic busy_ff;
   always_ff @(posedge clock) begin
      busy_ff <= cmd.op == OP_NMS || cmd.op == OP_HYST;
      if (busy_ff && tap_ff == 4'd4) begin
         centre_ff <= rd_ff;
      end
      if (cmd.start) begin
         n1_ff <= 8'd0;
         n2_ff <= 8'd0;
         strong_ff <= 1'b0;
      end else if (busy_ff) begin
         if (tap_ff == t1) n1_ff <= tv;
         if (tap_ff == t2) n2_ff <= tv;
         if (tv > high_th) strong_ff <= 1'b1;
      end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_data = centre_ff;
      if (cmd.finish && cmd.op == OP_NMS) begin
         wr_en = centre_ff < n1_ff || centre_ff < n2_ff;
         wr_data = 8'd0;
      end else if (cmd.finish && cmd.op == OP_HYST) begin
         wr_en = 1'b1;
         if (centre_ff > high_th) wr_data = 8'd255;
         else if (centre_ff < low_th) wr_data = 8'd0;
         else if (centre_ff < high_th && centre_ff > low_th)
            wr_data = strong_ff ? 8'd255 : 8'd0;
      end
   end

   logic rdv_ff;
   always_ff @(posedge clock) rdv_ff <= cmd.op == OP_READ;
   assign status.rd_valid = rdv_ff;
   assign rd_data = rd_ff;
endmodule

@@ rtl/cnh_controller.sv @@
// Sequencer for loading, the two processing sweeps and reading.
`timescale 1ns / 1ps
module cnh_controller #(
   parameter int MAX_WIDTH  = cnh_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cnh_pkg::DEF_MAX_HEIGHT,
   parameter int XW = $clog2(MAX_WIDTH + 1),
   parameter int YW = $clog2(MAX_HEIGHT + 1),
   parameter int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_mode,
   output logic             in_ready,
   input  logic             out_free,   // result register can take an item
   input  logic [XW-1:0]    eff_w,
   input  logic [YW-1:0]    eff_h,
   output cnh_pkg::cmd_type cmd,
   output logic [AW-1:0]    addr,
   output logic [XW-1:0]    pos_x,
   output logic [YW-1:0]    pos_y,
   output logic             rd_last,
   output logic             rd_zero
);
   import cnh_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_NMS  = 5'b00010,
      ST_HYST = 5'b00100,
      ST_READ = 5'b01000,
      ST_WAIT = 5'b10000
   } state_type;

   localparam int SZW = AW + 1;

   state_type state_ff, state_in;
   logic [AW-1:0]  lpos_ff, lpos_in, rpos_ff, rpos_in, ppos_ff, ppos_in;
   logic [XW-1:0]  x_ff, x_in;
   logic [YW-1:0]  y_ff, y_in;
   logic [3:0]     step_ff, step_in;
   logic           proc_ff, proc_in;
   logic           last_ff, last_in, zero_ff, zero_in;
   logic [SZW-1:0] size;

   assign size = SZW'(eff_w * eff_h);

   always_comb begin
      state_in = state_ff;
      lpos_in = lpos_ff; rpos_in = rpos_ff; ppos_in = ppos_ff;
      x_in = x_ff; y_in = y_ff; step_in = step_ff; proc_in = proc_ff;
      last_in = last_ff; zero_in = zero_ff;
      cmd = '0; cmd.op = OP_NONE;
      in_ready = 1'b0;
      addr = ppos_ff;
      case (state_ff)
         ST_IDLE: begin
            in_ready = out_free;
            addr = in_mode ? rpos_ff : lpos_ff;
            if (in_valid && out_free) begin
               if (!in_mode) begin
                  cmd.op = OP_LOAD;
                  if (lpos_ff == '0) begin
                     proc_in = 1'b0;
                     rpos_in = '0;
                  end
                  if (SZW'(lpos_ff) + 1'b1 >= size) begin
                     lpos_in = '0; ppos_in = '0; x_in = '0; y_in = '0;
                     step_in = '0; state_in = ST_NMS;
                  end else begin
                     lpos_in = lpos_ff + 1'b1;
                  end
               end else if (proc_ff) begin
                  if (SZW'(rpos_ff) >= size) begin
                     zero_in = 1'b1; last_in = 1'b1; rpos_in = '0;
                  end else begin
                     cmd.op = OP_READ; zero_in = 1'b0;
                     last_in = SZW'(rpos_ff) + 1'b1 >= size;
                     rpos_in = last_in ? '0 : rpos_ff + 1'b1;
                  end
                  state_in = ST_READ;
               end else begin
                  // A read before processing yields no item.
                  zero_in = 1'b0;
               end
            end
         end
         ST_NMS, ST_HYST: begin
            // Steps 0..8 fetch the window, 9 collects the last tap, 10 writes back.
            cmd.op = (state_ff == ST_NMS) ? OP_NMS : OP_HYST;
            cmd.tap = (step_ff < 4'd9) ? step_ff : 4'd15;
            cmd.start = step_ff == 4'd0;
            cmd.finish = step_ff == 4'd10;
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd10) begin
               step_in = '0;
               if (SZW'(ppos_ff) + 1'b1 >= size) begin
                  ppos_in = '0; x_in = '0; y_in = '0;
                  if (state_ff == ST_NMS) state_in = ST_HYST;
                  else begin state_in = ST_IDLE; proc_in = 1'b1; end
               end else begin
                  ppos_in = ppos_ff + 1'b1;
                  if (x_ff + 1'b1 >= eff_w) begin x_in = '0; y_in = y_ff + 1'b1; end
                  else x_in = x_ff + 1'b1;
               end
            end
         end
         ST_READ: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lpos_ff <= '0; rpos_ff <= '0; proc_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         lpos_ff <= lpos_in; rpos_ff <= rpos_in; proc_ff <= proc_in;
         step_ff <= step_in;
      end
      ppos_ff <= ppos_in; x_ff <= x_in; y_ff <= y_in;
      last_ff <= last_in; zero_ff <= zero_in;
   end

   assign pos_x = x_ff;
   assign pos_y = y_ff;
   assign rd_last = last_ff;
   assign rd_zero = zero_ff;
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Canny suppression and hysteresis back end.
`timescale 1ns / 1ps
module tb;
   import cnh_pkg::*;

   localparam int FRAME_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int STALL_LIMIT = 200000;

   typedef struct {
      bit        mode;
      bit [7:0]  mag;
      bit [11:0] ang;
   } pixel_item_type;

   typedef struct {
      bit [7:0] edge_val;
      bit       last_px;
   } edge_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_HIGH;
   logic [9:0]  csr_wdata = '0;

   canny_nms_hysteresis u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Predicted state of the block.
   bit [7:0]  mag_mem [FRAME_DEPTH];
   bit [1:0]  dir_mem [FRAME_DEPTH];
   int        load_pos, read_pos;
   bit        processed;
   bit [7:0]  thr_high = 8'd100, thr_low = 8'd80;
   bit [9:0]  cfg_width = 10'd640;
   bit [8:0]  cfg_height = 9'd480;

   pixel_item_type  pixel_q[$];
   edge_result_type edge_q[$];
   pixel_item_type  cur_item;
   int  tx_idle_pct = 12, rx_idle_pct = 82;
   int  items_queued = 0, loads_done = 0, reads_done = 0, results_seen = 0;
   int  frames_done = 0, mismatches = 0;
   bit  hold_armed = 0, hold_done = 0;
   int  hold_count = 0;
   int  quiet_cycles = 0;

   function automatic int used_width();
      if (cfg_width == 0) return 1;
      return (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cfg_width);
   endfunction

   function automatic int used_height();
      if (cfg_height == 0) return 1;
      return (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(cfg_height);
   endfunction

   function automatic bit [1:0] direction_bin(bit [11:0] ang);
      int a;
      a = ang;
      if (a > 1800) a -= 1800;
      // Anything still above 1800 after one fold counts as horizontal.
      if (a <= 225 || a >= 1575) return DIR_HORZ;
      if (a <= 675) return DIR_DIAG;
      if (a <= 1125) return DIR_VERT;
      return DIR_ANTI;
   endfunction

   function automatic int neighbour(int y, int x, int w, int h);
      if (y < 0 || y >= h || x < 0 || x >= w) return 0;
      return mag_mem[y * w + x];
   endfunction

   function automatic void thin_and_link();
      int w, h, idx, c, n1, n2;
      bit strong_hit;
      w = used_width();
      h = used_height();
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            idx = y * w + x;
            c = mag_mem[idx];
            case (dir_mem[idx])
               DIR_HORZ: begin n1 = neighbour(y, x - 1, w, h); n2 = neighbour(y, x + 1, w, h); end
               DIR_DIAG: begin
                  n1 = neighbour(y + 1, x + 1, w, h); n2 = neighbour(y - 1, x - 1, w, h);
               end
               DIR_VERT: begin n1 = neighbour(y + 1, x, w, h); n2 = neighbour(y - 1, x, w, h); end
               default: begin
                  n1 = neighbour(y - 1, x + 1, w, h); n2 = neighbour(y + 1, x - 1, w, h);
               end
            endcase
            if (c < n1 || c < n2) mag_mem[idx] = 8'd0;
         end
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            idx = y * w + x;
            c = mag_mem[idx];
            if (c > thr_high) mag_mem[idx] = 8'd255;
            else if (c < thr_low) mag_mem[idx] = 8'd0;
            else if (c < thr_high && c > thr_low) begin
               strong_hit = 0;
               for (int k = -1; k <= 1; k++)
                  for (int l = -1; l <= 1; l++)
                     if (neighbour(y + k, x + l, w, h) > thr_high) strong_hit = 1;
               mag_mem[idx] = strong_hit ? 8'd255 : 8'd0;
            end
         end
   endfunction

   function automatic void predict_item(pixel_item_type it);
      int fsize;
      edge_result_type r;
      fsize = used_width() * used_height();
      if (!it.mode) begin
         loads_done++;
         if (load_pos == 0) begin
            processed = 0;
            read_pos = 0;
         end
         if (load_pos < FRAME_DEPTH) begin
            mag_mem[load_pos] = it.mag;
            dir_mem[load_pos] = direction_bin(it.ang);
         end
         load_pos++;
         if (load_pos >= fsize) begin
            thin_and_link();
            processed = 1;
            load_pos = 0;
            frames_done++;
         end
      end else begin
         reads_done++;
         if (!processed) return;
         if (read_pos >= fsize) begin
            r.edge_val = 8'd0;
            r.last_px = 1;
            read_pos = 0;
         end else begin
            r.edge_val = mag_mem[read_pos];
            r.last_px = (read_pos + 1 >= fsize);
            read_pos = r.last_px ? 0 : read_pos + 1;
         end
         edge_q.push_back(r);
      end
   endfunction

   // Sender: predicts each item as it is accepted, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_item(cur_item);
         if (!req_tvalid || req_tready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               cur_item = pixel_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_item.mode;
               req_tdata <= {4'd0, cur_item.ang, cur_item.mag};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks results and, once, holds off for a long stretch.
   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (edge_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result value %0d last %0b", rsp_tdata, rsp_tlast);
            end else begin
               want = edge_q.pop_front();
               if (rsp_tdata !== want.edge_val || rsp_tlast !== want.last_px) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: result expected value %0d last %0b, got %0d last %0b",
                              want.edge_val, want.last_px, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (hold_armed && !hold_done && (rsp_tvalid || hold_count > 0)) begin
            hold_count <= hold_count + 1;
            if (hold_count >= 600) hold_done <= 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR: nothing accepted for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic add_item(bit mode, bit [7:0] mag, bit [11:0] ang);
      pixel_item_type it;
      it.mode = mode;
      it.mag = mag;
      it.ang = ang;
      pixel_q.push_back(it);
      items_queued++;
   endtask

   task automatic add_reads(int n);
      for (int i = 0; i < n; i++) add_item(1'b1, 8'($urandom), 12'($urandom));
   endtask

   // Waits until the block has drained and any processing pass has finished.
   task automatic wait_idle();
      wait (pixel_q.size() == 0 && !req_tvalid && edge_q.size() == 0);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 10'(val);
      case (idx)
         REG_HIGH:  thr_high = 8'(val);
         REG_LOW:   thr_low = 8'(val);
         REG_WIDTH: cfg_width = 10'(val);
         default:   cfg_height = 9'(val);
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_frame(int hi, int lo, int w, int h);
      wait_idle();
      write_reg(REG_HIGH, hi);
      write_reg(REG_LOW, lo);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   function automatic bit [7:0] near_threshold();
      case ($urandom_range(5))
         0: return thr_high;
         1: return thr_low;
         2: return thr_high + 8'($urandom_range(2)) - 8'd1;
         3: return thr_low + 8'($urandom_range(2)) - 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      bit [11:0] dir_angles[16] = '{0, 225, 226, 675, 676, 1125, 1126, 1574,
                                    1575, 1800, 1801, 2025, 2500, 3599, 3600, 4095};
      bit [7:0]  dir_mags[16] = '{255, 0, 200, 50, 120, 201, 49, 199,
                                  51, 255, 128, 0, 200, 50, 100, 180};
      int fsize, hi, lo, w, h, rand_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reads with no processed frame yield nothing.
      add_reads(2);
      set_frame(200, 50, 4, 4);
      for (int i = 0; i < 16; i++) begin
         add_item(1'b0, dir_mags[i], dir_angles[i]);
         if (i == 2) add_reads(1);
      end
      add_reads(22);
      // Shrinking the frame leaves the read position beyond it.
      set_frame(200, 50, 2, 2);
      add_reads(3);
      // A shrink part-way through a load completes the frame early.
      set_frame(150, 60, 4, 4);
      for (int i = 0; i < 5; i++) add_item(1'b0, 8'($urandom), 12'($urandom_range(3599)));
      set_frame(150, 60, 2, 2);
      add_item(1'b0, 8'd255, 12'd900);
      add_reads(5);
      // Extreme settings: zero sizes, oversize sizes, threshold extremes.
      set_frame(0, 0, 0, 0);
      add_item(1'b0, 8'd0, 12'd4095);
      add_reads(2);
      set_frame(255, 255, 1023, 1);
      for (int i = 0; i < 640; i++) add_item(1'b0, 8'($urandom), 12'($urandom));
      add_reads(20);
      set_frame(255, 0, 1, 511);
      for (int i = 0; i < 480; i++) add_item(1'b0, near_threshold(), 12'($urandom_range(3599)));
      add_reads(20);

      rand_start = items_queued;
      hold_armed = 1;
      while (items_queued < 1650) begin
         if (items_queued - rand_start > 2 * (1650 - rand_start) / 3) begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end else if (items_queued - rand_start > (1650 - rand_start) / 3) begin
            tx_idle_pct = 82; rx_idle_pct = 12;
         end
         if ($urandom_range(2) == 0 || items_queued == rand_start) begin
            hi = ($urandom_range(9) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
            lo = ($urandom_range(9) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
            w = ($urandom_range(15) == 0) ? 0 : $urandom_range(8, 1);
            h = ($urandom_range(15) == 0) ? 0 : $urandom_range(8, 1);
            set_frame(hi, lo, w, h);
         end
         fsize = used_width() * used_height();
         for (int i = 0; i < fsize; i++) begin
            add_item(1'b0, near_threshold(),
                     ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(3599)));
            if ($urandom_range(9) == 0) add_reads(1);
         end
         add_reads($urandom_range(2 * fsize + 2));
      end

      wait_idle();
      $display("Covered %0d frames: %0d loads and %0d reads, %0d results checked.",
               frames_done, loads_done, reads_done, results_seen);
      $display("Thresholds and sizes swept through their extremes, with stalls on both sides.");
      if (mismatches == 0 && edge_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches, edge_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
